[sv/prst_pkg.sv]
// Shared types and constants for the point rotate/scale/translate block.
// Holds register indexes, setup sequencer states and the rotation setup struct.
// No dependencies.
package prst_pkg;

    localparam int PART_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS   = 3'd4;

    localparam logic [3*PART_W-1:0] SCALE_RESET = 48'h0100_0100_0100;
    localparam logic [3*PART_W-1:0] AXIS_RESET  = 48'h4000_0000_0000;

    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;

    localparam logic [30:0] S_A1 = 31'd1686629713;
    localparam logic [30:0] S_A3 = 31'd693598668;
    localparam logic [30:0] S_A5 = 31'd85569306;
    localparam logic [30:0] S_A7 = 31'd5026995;
    localparam logic [30:0] S_A9 = 31'd172272;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SQ,
        ST_X2,
        ST_MUL,
        ST_SUB,
        ST_FMUL,
        ST_FIN,
        ST_SQRT,
        ST_DIVLD,
        ST_DIV,
        ST_DIVST,
        ST_IDLE
    } t_seq_state;

    typedef struct packed {
        logic               rot_en;
        logic signed [15:0] sn;
        logic signed [15:0] cs;
        logic signed [15:0] kx;
        logic signed [15:0] ky;
        logic signed [15:0] kz;
    } t_rot;

    function automatic logic [30:0] poly_coef(input logic [1:0] idx);
        logic [30:0] c;
        unique case (idx)
            2'd0: c = S_A7;
            2'd1: c = S_A5;
            2'd2: c = S_A3;
            default: c = S_A1;
        endcase
        return c;
    endfunction

endpackage

[sv/prst_if.sv]
// Stream and configuration channel interfaces for the point transform block.
// Depends on prst_pkg for the configuration index and data widths.
interface prst_point_if #(parameter int CW = 20);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface prst_result_if #(parameter int CW = 20);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

interface prst_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [prst_pkg::CFG_IDX_W-1:0]     index;
    logic [prst_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/prst_setup.sv]
// Configuration registers and setup sequencer: sine/cosine by shared multiplier,
// axis normalisation by bit-serial square root and restoring division.
// Depends on prst_pkg and prst_if.
module prst_setup import prst_pkg::*; #(
    parameter int CW = 20,
    parameter int AW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    prst_cfg_if.sink             i_cfg,
    output logic [3*CW-1:0]      o_pivot,
    output logic [3*PART_W-1:0]  o_scale,
    output logic [3*CW-1:0]      o_offset,
    output t_rot                 o_rot,
    output logic                 o_busy
);

    logic [3*CW-1:0]     r_pivot;
    logic [3*PART_W-1:0] r_scale;
    logic [3*CW-1:0]     r_offset;
    logic [AW-1:0]       r_angle;
    logic [3*PART_W-1:0] r_axis;

    t_seq_state r_state, n_state;

    logic               r_which;
    logic [30:0]        r_x;
    logic [30:0]        r_x2;
    logic [30:0]        r_t;
    logic [61:0]        r_prod;
    logic [5:0]         r_cnt;
    logic [14:0]        r_s;
    logic [31:0]        r_norm2;
    logic [59:0]        r_sq_x;
    logic [59:0]        r_res;
    logic [30:0]        r_mag;
    logic [45:0]        r_rem;
    logic [15:0]        r_q;
    logic [1:0]         r_ax;
    logic signed [15:0] r_k [3];
    logic signed [15:0] r_sn;
    logic signed [15:0] r_cs;

    logic               cfg_wr;
    logic [31:0]        phase;
    logic [30:0]        mul_a;
    logic [30:0]        mul_b;
    logic [61:0]        mul_p;
    logic [31:0]        q30;
    logic [16:0]        q14_raw;
    logic [14:0]        q14;
    logic [60:0]        sq_bit;
    logic [60:0]        sq_try;
    logic               sq_take;
    logic [59:0]        n_sq_x;
    logic [59:0]        n_res;
    logic [45:0]        div_sub;
    logic               div_take;
    logic signed [15:0] ax_comp;
    logic [15:0]        ax_mag;
    logic [15:0]        q_clamp;
    logic signed [15:0] a_part [3];
    logic [31:0]        norm2;

    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign phase       = {r_angle, {(32-AW){1'b0}}};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_part[i] = $signed(r_axis[i*PART_W +: PART_W]);
        end
        norm2 = 32'(a_part[0]) * 32'(a_part[0]) + 32'(a_part[1]) * 32'(a_part[1])
                + 32'(a_part[2]) * 32'(a_part[2]);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:  n_state = ST_SQ;
            ST_SQ:    n_state = ST_X2;
            ST_X2:    n_state = ST_MUL;
            ST_MUL:   n_state = ST_SUB;
            ST_SUB:   n_state = (r_cnt[1:0] == 2'd3) ? ST_FMUL : ST_MUL;
            ST_FMUL:  n_state = ST_FIN;
            ST_FIN:   n_state = r_which ? ST_SQRT : ST_SQ;
            ST_SQRT: begin
                if (r_cnt == 6'd0) begin
                    n_state = (r_norm2 == '0) ? ST_IDLE : ST_DIVLD;
                end
            end
            ST_DIVLD: n_state = ST_DIV;
            ST_DIV:   n_state = (r_cnt == 6'd0) ? ST_DIVST : ST_DIV;
            ST_DIVST: n_state = (r_ax == 2'd2) ? ST_IDLE : ST_DIVLD;
            ST_IDLE:  n_state = ST_IDLE;
            default:  n_state = ST_LOAD;
        endcase
        if (cfg_wr) begin
            n_state = ST_LOAD;
        end
    end

    always_comb begin
        mul_a = r_t;
        mul_b = r_x;
        unique case (r_state)
            ST_SQ:   begin mul_a = r_x; mul_b = r_x;  end
            ST_MUL:  begin mul_a = r_t; mul_b = r_x2; end
            default: begin mul_a = r_t; mul_b = r_x;  end
        endcase
    end

    always_comb begin
        mul_p    = 62'(mul_a) * 62'(mul_b);
        q30      = 32'(r_prod >> 30);
        q14_raw  = 17'((33'(q30) + 33'd32768) >> 16);
        q14      = (q14_raw > 17'(ONE_Q14)) ? ONE_Q14 : q14_raw[14:0];
        sq_bit   = 61'd1 << r_cnt;
        sq_try   = 61'(r_res) + sq_bit;
        sq_take  = 61'(r_sq_x) >= sq_try;
        n_sq_x   = sq_take ? 60'(61'(r_sq_x) - sq_try) : r_sq_x;
        n_res    = sq_take ? 60'(61'(r_res >> 1) + sq_bit) : (r_res >> 1);
        div_sub  = 46'(r_mag) << r_cnt[3:0];
        div_take = r_rem >= div_sub;
        ax_comp  = a_part[r_ax];
        ax_mag   = ax_comp[15] ? 16'(-ax_comp) : 16'(ax_comp);
        q_clamp  = (r_q > 16'(ONE_Q14)) ? 16'(ONE_Q14) : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_pivot  <= '0;
            r_scale  <= SCALE_RESET;
            r_offset <= '0;
            r_angle  <= '0;
            r_axis   <= AXIS_RESET;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                unique case (i_cfg.index)
                    CFG_PIVOT:  r_pivot  <= i_cfg.data[3*CW-1:0];
                    CFG_SCALE:  r_scale  <= i_cfg.data[3*PART_W-1:0];
                    CFG_OFFSET: r_offset <= i_cfg.data[3*CW-1:0];
                    CFG_ANGLE:  r_angle  <= i_cfg.data[AW-1:0];
                    CFG_AXIS:   r_axis   <= i_cfg.data[3*PART_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_LOAD: begin
                r_which <= 1'b0;
                r_x     <= {1'b0, phase[29:0]};
                r_norm2 <= norm2;
            end
            ST_SQ:   r_prod <= mul_p;
            ST_X2: begin
                r_x2  <= 31'(r_prod >> 30);
                r_t   <= S_A9;
                r_cnt <= '0;
            end
            ST_MUL:  r_prod <= mul_p;
            ST_SUB: begin
                r_t   <= 31'(poly_coef(r_cnt[1:0]) - 31'(r_prod >> 30));
                r_cnt <= r_cnt + 6'd1;
            end
            ST_FMUL: r_prod <= mul_p;
            ST_FIN: begin
                if (!r_which) begin
                    r_s     <= q14;
                    r_which <= 1'b1;
                    r_x     <= ONE_Q30 - {1'b0, phase[29:0]};
                end else begin
                    unique case (phase[31:30])
                        2'd0: begin r_sn <= 16'(r_s);   r_cs <= 16'(q14);   end
                        2'd1: begin r_sn <= 16'(q14);   r_cs <= -16'(r_s);  end
                        2'd2: begin r_sn <= -16'(r_s);  r_cs <= -16'(q14);  end
                        default: begin r_sn <= -16'(q14); r_cs <= 16'(r_s); end
                    endcase
                    r_sq_x <= 60'(r_norm2) << 28;
                    r_res  <= '0;
                    r_cnt  <= 6'd58;
                end
            end
            ST_SQRT: begin
                r_sq_x <= n_sq_x;
                r_res  <= n_res;
                r_cnt  <= r_cnt - 6'd2;
                r_mag  <= 31'(n_res);
                r_ax   <= '0;
            end
            ST_DIVLD: begin
                r_rem <= (46'(ax_mag) << 28) + 46'(r_mag >> 1);
                r_q   <= '0;
                r_cnt <= 6'd15;
            end
            ST_DIV: begin
                if (div_take) begin
                    r_rem <= r_rem - div_sub;
                    r_q[r_cnt[3:0]] <= 1'b1;
                end
                r_cnt <= r_cnt - 6'd1;
            end
            ST_DIVST: begin
                r_k[r_ax] <= ax_comp[15] ? -q_clamp : q_clamp;
                r_ax      <= r_ax + 2'd1;
            end
            default: ;
        endcase
    end

    assign o_pivot      = r_pivot;
    assign o_scale      = r_scale;
    assign o_offset     = r_offset;
    assign o_busy       = r_state != ST_IDLE;
    assign o_rot.rot_en = (r_angle != '0) && (r_norm2 != '0);
    assign o_rot.sn     = r_sn;
    assign o_rot.cs     = r_cs;
    assign o_rot.kx     = r_k[0];
    assign o_rot.ky     = r_k[1];
    assign o_rot.kz     = r_k[2];

`ifndef NO_ASSERTIONS
    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> r_state == ST_LOAD)
        else $error("setup not restarted after configuration transfer");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_mag != '0)
        else $error("division by zero magnitude");
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) && !cfg_wr |=> r_state == ST_IDLE)
        else $error("setup left idle without configuration transfer");
`endif

endmodule

[sv/prst_datapath.sv]
// Nine-stage transform pipeline: pivot offset, Rodrigues rotation, scale,
// translate and saturate. Uses rotation setup from prst_setup; depends on prst_pkg.
module prst_datapath import prst_pkg::*; #(
    parameter int CW = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    prst_point_if.sink          i_pt,
    prst_result_if.source       o_res,
    input  logic [3*CW-1:0]     i_pivot,
    input  logic [3*PART_W-1:0] i_scale,
    input  logic [3*CW-1:0]     i_offset,
    input  t_rot                i_rot,
    input  logic                i_busy
);

    localparam int VW   = CW + 1;
    localparam int KVW  = VW + 16;
    localparam int CRW  = KVW + 1;
    localparam int DOTW = KVW + 2;
    localparam int DPW  = DOTW + 17;
    localparam int DDW  = DOTW + 3;
    localparam int KDW  = DDW + 16;
    localparam int CSW  = CRW + 16;
    localparam int VCW  = VW + 16;
    localparam int SUMW = DDW + 18;
    localparam int PW   = SUMW - 27;
    localparam int SPW  = PW + 16;
    localparam int RW   = SPW - 7;
    localparam logic signed [RW-1:0] SAT_HI = RW'(2**(CW-1) - 1);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

    logic                  en;
    logic                  [9:1] r_vld;

    logic signed [CW-1:0]  pin [3];
    logic signed [CW-1:0]  piv [3];
    logic signed [CW-1:0]  ofs [3];
    logic signed [15:0]    scl [3];
    logic signed [15:0]    k   [3];
    logic signed [16:0]    omc;

    logic signed [VW-1:0]  r1_v [3];
    logic signed [CW-1:0]  r1_p [3];
    logic signed [KVW-1:0] r2_kv [3][3];
    logic signed [VCW-1:0] r2_vcs [3];
    logic signed [CW-1:0]  r2_p [3];
    logic signed [CRW-1:0] r3_cr [3];
    logic signed [DOTW-1:0] r3_dot;
    logic signed [VCW-1:0] r3_vcs [3];
    logic signed [CW-1:0]  r3_p [3];
    logic signed [DPW-1:0] r4_dprod;
    logic signed [CSW-1:0] r4_crsn [3];
    logic signed [VCW-1:0] r4_vcs [3];
    logic signed [CW-1:0]  r4_p [3];
    logic signed [DDW-1:0] r5_dd;
    logic signed [CSW-1:0] r5_crsn [3];
    logic signed [VCW-1:0] r5_vcs [3];
    logic signed [CW-1:0]  r5_p [3];
    logic signed [KDW-1:0] r6_kdd [3];
    logic signed [CSW-1:0] r6_crsn [3];
    logic signed [VCW-1:0] r6_vcs [3];
    logic signed [CW-1:0]  r6_p [3];
    logic signed [PW-1:0]  r7_q [3];
    logic signed [SPW-1:0] r8_prod [3];
    logic signed [CW-1:0]  r9_o [3];

    logic signed [SUMW-1:0] sum [3];
    logic signed [RW-1:0]   fin [3];

    assign en         = !r_vld[9] || o_res.ready;
    assign i_pt.ready = en && !i_busy;

    always_comb begin
        pin[0] = i_pt.point_x;
        pin[1] = i_pt.point_y;
        pin[2] = i_pt.point_z;
        k[0]   = i_rot.kx;
        k[1]   = i_rot.ky;
        k[2]   = i_rot.kz;
        omc    = 17'sd16384 - 17'(i_rot.cs);
        for (int i = 0; i < 3; i++) begin
            piv[i] = $signed(i_pivot[i*CW +: CW]);
            ofs[i] = $signed(i_offset[i*CW +: CW]);
            scl[i] = $signed(i_scale[i*PART_W +: PART_W]);
            sum[i] = (SUMW'(r6_vcs[i]) <<< 14) + SUMW'(r6_crsn[i]) + SUMW'(r6_kdd[i])
                     + (SUMW'(1) <<< 27);
            fin[i] = RW'((r8_prod[i] + SPW'(128)) >>> 8) + RW'(ofs[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[8:1], i_pt.valid && !i_busy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_v[i] <= VW'(pin[i]) - VW'(piv[i]);
                r1_p[i] <= pin[i];

                for (int j = 0; j < 3; j++) begin
                    r2_kv[i][j] <= KVW'(k[i]) * KVW'(r1_v[j]);
                end
                r2_vcs[i] <= VCW'(r1_v[i]) * VCW'(i_rot.cs);
                r2_p[i]   <= r1_p[i];

                r3_vcs[i] <= r2_vcs[i];
                r3_p[i]   <= r2_p[i];

                r4_crsn[i] <= CSW'(r3_cr[i]) * CSW'(i_rot.sn);
                r4_vcs[i]  <= r3_vcs[i];
                r4_p[i]    <= r3_p[i];

                r5_crsn[i] <= r4_crsn[i];
                r5_vcs[i]  <= r4_vcs[i];
                r5_p[i]    <= r4_p[i];

                r6_kdd[i]  <= KDW'(k[i]) * KDW'(r5_dd);
                r6_crsn[i] <= r5_crsn[i];
                r6_vcs[i]  <= r5_vcs[i];
                r6_p[i]    <= r5_p[i];

                r7_q[i] <= i_rot.rot_en ? PW'(sum[i] >>> 28) + PW'(piv[i]) : PW'(r6_p[i]);

                r8_prod[i] <= SPW'(r7_q[i]) * SPW'(scl[i]);

                if (fin[i] > SAT_HI) begin
                    r9_o[i] <= CW'(SAT_HI);
                end else if (fin[i] < SAT_LO) begin
                    r9_o[i] <= CW'(SAT_LO);
                end else begin
                    r9_o[i] <= CW'(fin[i]);
                end
            end
            r3_cr[0] <= CRW'(r2_kv[1][2]) - CRW'(r2_kv[2][1]);
            r3_cr[1] <= CRW'(r2_kv[2][0]) - CRW'(r2_kv[0][2]);
            r3_cr[2] <= CRW'(r2_kv[0][1]) - CRW'(r2_kv[1][0]);
            r3_dot   <= DOTW'(r2_kv[0][0]) + DOTW'(r2_kv[1][1]) + DOTW'(r2_kv[2][2]);
            r4_dprod <= DPW'(r3_dot) * DPW'(omc);
            r5_dd    <= DDW'((r4_dprod + (DPW'(1) <<< 13)) >>> 14);
        end
    end

    assign o_res.valid = r_vld[9];
    assign o_res.out_x = r9_o[0];
    assign o_res.out_y = r9_o[1];
    assign o_res.out_z = r9_o[2];

endmodule

[sv/point_rotate_scale_translate_core.sv]
// Throughput one point per cycle while setup is idle and the output is not stalled.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// After reset and after each configuration transfer the setup sequencer runs: shared
// multiplier for sine/cosine, bit-serial root, restoring divider per axis component
// (skipped with a zero axis). Input ready stays low meanwhile.
// Reset is synchronous, active low; registers return to identity transform, axis +z.
module point_rotate_scale_translate_core import prst_pkg::*; #(
    parameter int COORD_WIDTH = 20,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    prst_point_if.sink    i_pt,
    prst_result_if.source o_res,
    prst_cfg_if.sink      i_cfg
);

    logic [3*COORD_WIDTH-1:0] pivot;
    logic [3*PART_W-1:0]      scale;
    logic [3*COORD_WIDTH-1:0] offset;
    t_rot                     rot;
    logic                     busy;

    prst_setup #(
        .CW (COORD_WIDTH),
        .AW (ANGLE_WIDTH)
    ) u_setup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_pivot  (pivot),
        .o_scale  (scale),
        .o_offset (offset),
        .o_rot    (rot),
        .o_busy   (busy)
    );

    prst_datapath #(
        .CW (COORD_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pt     (i_pt),
        .o_res    (o_res),
        .i_pivot  (pivot),
        .i_scale  (scale),
        .i_offset (offset),
        .i_rot    (rot),
        .i_busy   (busy)
    );

endmodule

[tb/prst_checker.sv]
// Checker for the point rotate/scale/translate core: mirrors the register file from
// configuration transfers, predicts each transformed point and compares results in order.
// Depends on prst_pkg and the channel interfaces in prst_if.sv.
module prst_checker import prst_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    prst_point_if  pt,
    prst_result_if res,
    prst_cfg_if    cfg,
    output int     o_errors,
    output int     o_pending,
    output int     o_results
);

    localparam longint COORD_HI = (64'sd1 <<< 19) - 1;
    localparam longint COORD_LO = -(64'sd1 <<< 19);

    typedef struct {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
    } t_point;

    t_point       moved_points_q[$];
    logic [59:0]  pivot_r;
    logic [47:0]  scale_r;
    logic [59:0]  offset_r;
    logic [15:0]  angle_r;
    logic [47:0]  axis_r;
    int           err_count;
    int           result_count;

    assign o_errors  = err_count;
    assign o_results = result_count;

    function automatic longint round_shift(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned acc;
        longint unsigned b;
        acc = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= acc + b) begin
                x = x - (acc + b);
                acc = (acc >> 1) + b;
            end else begin
                acc = acc >> 1;
            end
            b = b >> 2;
        end
        return acc;
    endfunction

    function automatic longint sine_q30(longint x);
        longint x2;
        longint t;
        x2 = (x * x) >>> 30;
        t = 172272;
        t = 5026995 - ((t * x2) >>> 30);
        t = 85569306 - ((t * x2) >>> 30);
        t = 693598668 - ((t * x2) >>> 30);
        t = 1686629713 - ((t * x2) >>> 30);
        return (t * x) >>> 30;
    endfunction

    function automatic longint q30_to_q14(longint q);
        longint v;
        v = (q + 32768) >>> 16;
        return (v > 16384) ? 64'sd16384 : v;
    endfunction

    function automatic longint unit_axis(longint a, longint unsigned mag);
        longint unsigned m;
        longint q;
        m = (a < 0) ? -a : a;
        q = ((m << 28) + mag / 2) / mag;
        if (q > 16384) q = 16384;
        return (a < 0) ? -q : q;
    endfunction

    function automatic t_point transform_point(logic signed [19:0] px, logic signed [19:0] py,
                                               logic signed [19:0] pz);
        longint          p[3], a[3], k[3], v[3], cr[3], pv[3];
        longint          sn, cs, s, c, rq, dot, dd, sum, r;
        longint unsigned norm2, mag;
        logic [31:0]     phase;
        t_point          o;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        for (int i = 0; i < 3; i++) begin
            a[i]  = $signed(axis_r[16*i +: 16]);
            pv[i] = $signed(pivot_r[20*i +: 20]);
        end
        norm2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        if (angle_r != 0 && norm2 != 0) begin
            phase = {angle_r, 16'h0000};
            rq = phase[29:0];
            s = q30_to_q14(sine_q30(rq));
            c = q30_to_q14(sine_q30(64'sd1073741824 - rq));
            case (phase[31:30])
                2'd0: begin sn = s;  cs = c;  end
                2'd1: begin sn = c;  cs = -s; end
                2'd2: begin sn = -s; cs = -c; end
                default: begin sn = -c; cs = s; end
            endcase
            mag = int_root(norm2 << 28);
            for (int i = 0; i < 3; i++) begin
                k[i] = unit_axis(a[i], mag);
                v[i] = p[i] - pv[i];
            end
            cr[0] = k[1] * v[2] - k[2] * v[1];
            cr[1] = k[2] * v[0] - k[0] * v[2];
            cr[2] = k[0] * v[1] - k[1] * v[0];
            dot = k[0] * v[0] + k[1] * v[1] + k[2] * v[2];
            dd = round_shift(dot * (16384 - cs), 14);
            for (int i = 0; i < 3; i++) begin
                sum = v[i] * cs * 16384 + cr[i] * sn + k[i] * dd;
                p[i] = round_shift(sum, 28) + pv[i];
            end
        end
        for (int i = 0; i < 3; i++) begin
            r = round_shift(p[i] * longint'($signed(scale_r[16*i +: 16])), 8);
            r = r + longint'($signed(offset_r[20*i +: 20]));
            if (r > COORD_HI) r = COORD_HI;
            if (r < COORD_LO) r = COORD_LO;
            p[i] = r;
        end
        o.x = p[0][19:0];
        o.y = p[1][19:0];
        o.z = p[2][19:0];
        return o;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH result %0d: %s", result_count, msg);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_point e;
        if (!i_rst_n) begin
            pivot_r      = '0;
            scale_r      = SCALE_RESET;
            offset_r     = '0;
            angle_r      = '0;
            axis_r       = AXIS_RESET;
            err_count    = 0;
            result_count = 0;
            moved_points_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_PIVOT:  pivot_r  = cfg.data[59:0];
                    CFG_SCALE:  scale_r  = cfg.data[47:0];
                    CFG_OFFSET: offset_r = cfg.data[59:0];
                    CFG_ANGLE:  angle_r  = cfg.data[15:0];
                    CFG_AXIS:   axis_r   = cfg.data[47:0];
                    default: ;
                endcase
            end
            if (pt.valid && pt.ready)
                moved_points_q.push_back(transform_point(pt.point_x, pt.point_y, pt.point_z));
            if (res.valid && res.ready) begin
                if (moved_points_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d,%0d,%0d",
                                              res.out_x, res.out_y, res.out_z));
                end else begin
                    e = moved_points_q.pop_front();
                    if (res.out_x !== e.x)
                        report_mismatch($sformatf("out_x expected %0d got %0d",
                                                  e.x, res.out_x));
                    if (res.out_y !== e.y)
                        report_mismatch($sformatf("out_y expected %0d got %0d",
                                                  e.y, res.out_y));
                    if (res.out_z !== e.z)
                        report_mismatch($sformatf("out_z expected %0d got %0d",
                                                  e.z, res.out_z));
                end
                result_count++;
            end
        end
        o_pending <= moved_points_q.size();
    end

endmodule

[tb/tb.sv]
// Testbench top for point_rotate_scale_translate_core: drives points and register
// writes under varied idling, and gives the verdict from prst_checker's error count.
// Depends on prst_pkg, prst_if.sv, prst_checker and the core.
module tb import prst_pkg::*; ();

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
    localparam int WATCHDOG_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, results;
    int   sent;
    int   idle_pct, stall_pct;
    int   quiet_cycles;

    prst_point_if  #(20) pt_if ();
    prst_result_if #(20) res_if ();
    prst_cfg_if          cfg_if ();

    point_rotate_scale_translate_core #(.COORD_WIDTH(20), .ANGLE_WIDTH(16)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    prst_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .pt       (pt_if),
        .res      (res_if),
        .cfg      (cfg_if),
        .o_errors (errors),
        .o_pending(pending),
        .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    task automatic end_writes();
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_point(logic [19:0] x, logic [19:0] y, logic [19:0] z);
        while ($urandom_range(99) < idle_pct) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid   <= 1'b1;
        pt_if.point_x <= x;
        pt_if.point_y <= y;
        pt_if.point_z <= z;
        do @(posedge i_clk); while (!pt_if.ready);
        sent++;
    endtask

    task automatic drain();
        pt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic logic [19:0] rand_coord();
        case ($urandom_range(9))
            0: return 20'h7ffff;
            1: return 20'h80000;
            2, 3: return 20'($signed($urandom_range(2047)) - 1024);
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_scale();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'h0100;
            default: return 16'h0100 + 16'($urandom_range(255)) - 16'd128;
        endcase
    endfunction

    function automatic logic [47:0] rand_axis();
        case ($urandom_range(9))
            0: return '0;
            1: return 48'($urandom) << (16 * $urandom_range(2));
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [63:0] rand_place();
        if ($urandom_range(3) == 0)
            return {$urandom, $urandom};
        return {4'h0, 8'h00, 12'($urandom), 8'h00, 12'($urandom), 8'h00, 12'($urandom)};
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        pt_if.valid   = 1'b0;
        pt_if.point_x = '0;
        pt_if.point_y = '0;
        pt_if.point_z = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        sent          = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity transform straight out of reset
        send_point(20'h7ffff, 20'h7ffff, 20'h7ffff);
        send_point(20'h80000, 20'h80000, 20'h80000);
        send_point(20'h00000, 20'h00001, 20'hfffff);
        send_point(20'h7ffff, 20'h80000, 20'h00100);
        drain();

        // quarter turn about +z around an offset pivot
        write_reg(CFG_ANGLE, 64'h4000);
        write_reg(CFG_PIVOT, {4'h0, 20'h00000, 20'h00200, 20'h00100});
        end_writes();
        send_point(20'h00100, 20'h00000, 20'h00000);
        send_point(20'h7ffff, 20'h80000, 20'h12345);
        send_point(20'h80000, 20'h7ffff, 20'h00000);
        drain();

        // half turn, most negative axis component, smallest angle and the angle just below a half turn
        write_reg(CFG_ANGLE, 64'h8000);
        write_reg(CFG_AXIS, 64'h0000_0000_0000_8000);
        end_writes();
        send_point(20'h00400, 20'h00300, 20'h00200);
        send_point(20'h7ffff, 20'h7ffff, 20'h80000);
        drain();
        write_reg(CFG_ANGLE, 64'h0001);
        write_reg(CFG_AXIS, 64'h0000_7fff_7fff_7fff);
        end_writes();
        send_point(20'h01000, 20'h80000, 20'h7ffff);
        drain();
        write_reg(CFG_ANGLE, 64'h7fff);
        write_reg(CFG_AXIS, 64'h0000_8000_8000_8000);
        end_writes();
        send_point(20'h01000, 20'h02000, 20'h80000);
        drain();

        // zero axis with a nonzero angle skips the rotation
        write_reg(CFG_AXIS, 64'h0);
        end_writes();
        send_point(20'h00321, 20'h80000, 20'h7ffff);
        drain();

        // saturating scale and offset, plus a write to an unused index
        write_reg(CFG_SCALE, 64'h0000_7fff_8000_7fff);
        write_reg(CFG_OFFSET, {4'hf, 20'h7ffff, 20'h80000, 20'h7ffff});
        write_reg(CFG_UNUSED, 64'hffff_ffff_ffff_ffff);
        end_writes();
        send_point(20'h7ffff, 20'h7ffff, 20'h80000);
        send_point(20'h80000, 20'h00001, 20'h7ffff);
        send_point(20'h00000, 20'h00000, 20'h00000);
        send_point(20'h00001, 20'hfffff, 20'h00100);
        drain();
        write_reg(CFG_SCALE, 64'h0);
        write_reg(CFG_OFFSET, 64'h0);
        write_reg(CFG_PIVOT, {4'h0, 20'h80000, 20'h7ffff, 20'h80000});
        write_reg(CFG_AXIS, 64'(AXIS_RESET));
        write_reg(CFG_ANGLE, 64'hc000);
        end_writes();
        send_point(20'h7ffff, 20'h7ffff, 20'h7ffff);
        drain();
        write_reg(CFG_SCALE, 64'(SCALE_RESET));
        end_writes();
        send_point(20'h7ffff, 20'h7ffff, 20'h7ffff);
        send_point(20'h80000, 20'h80000, 20'h80000);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CFG_PIVOT, rand_place());
            write_reg(CFG_SCALE, 64'({rand_scale(), rand_scale(), rand_scale()}));
            write_reg(CFG_OFFSET, rand_place());
            write_reg(CFG_ANGLE, ($urandom_range(7) == 0) ? 64'h0 : 64'($urandom));
            write_reg(CFG_AXIS, 64'(rand_axis()));
            end_writes();
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            for (int n = 0; n < 62; n++) begin
                if (ph == 3 && n == 31) begin
                    pt_if.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end

        $display("covered %0d points (%0d results) over directed cases and 12 random",
                 sent, results);
        $display("register settings with no, sender, receiver and mixed idling");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
